>>> design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared codes, default sizes and controller/datapath interface types for the
// key-value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Request opcodes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_REPLACE = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;     // load the request and restart the slot walk
    logic rd_en;     // read the slot under the walk pointer, advance
    logic sweep_wr;  // invalidate the slot under the walk pointer, advance
    logic commit;    // apply the update and load the result register
  } kvt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic walk_last; // walk pointer sits on the last slot
    logic out_free;  // result register can take a new result
    logic in_lookup; // incoming opcode needs a key search
    logic in_clear;  // incoming opcode is clear
  } kvt_sts_t;

endpackage

>>> design/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer for the key-value table: reset sweep, slot walk, clear sweep and
// commit of each request.
// ----------------------------------------------------------------------------
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kvt_sts_t sts,
  output kvt_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.walk_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.in_lookup) begin
            state_next = S_SCAN;
          end else if (sts.in_clear) begin
            state_next = S_SWEEP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

>>> design/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// Slot memory, walk pointer, match and free-slot trackers, entry count and
// result register of the key-value table.
// ----------------------------------------------------------------------------
module kvt_datapath
  import kvt_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  kvt_cmd_t    cmd,
  output kvt_sts_t    sts,
  input  logic [2:0]  opcode,
  input  logic [31:0] lookup_key,
  input  logic [31:0] entry_value,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        hit,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VAL_W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int WORD_W = 1 + KEY_W + VAL_W;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  // Slot word: {valid, key, value}
  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata;

  logic [2:0]       item_op;
  logic [KEY_W-1:0] item_key;
  logic [VAL_W-1:0] item_val;

  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pending;

  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic [VAL_W-1:0] hit_val;
  logic             have_free;
  logic [IDX_W-1:0] free_idx;

  logic [OCC_W-1:0] occupancy, occupancy_next;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic              hit_next;
  logic [31:0]       read_value_next;
  logic [1:0]        status_next;

  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  assign rd_valid = rdata[WORD_W-1];
  assign rd_key   = rdata[KEY_W+VAL_W-1:VAL_W];
  assign rd_val   = rdata[VAL_W-1:0];

  assign sts.walk_last = (walk_idx == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.in_lookup = opcode inside {OP_PUT, OP_GET, OP_REPLACE, OP_REMOVE};
  assign sts.in_clear  = (opcode == OP_CLEAR);

  // Hold the request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_op  <= opcode;
      item_key <= lookup_key[KEY_W-1:0];
      item_val <= entry_value[VAL_W-1:0];
    end
  end

  // Walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx   <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.rd_en;
      if (cmd.start) begin
        walk_idx <= '0;
      end else if (cmd.rd_en || cmd.sweep_wr) begin
        walk_idx <= walk_idx + IDX_W'(1);
      end
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata  <= mem[walk_idx];
      rd_idx <= walk_idx;
    end
  end

  // Match and lowest free slot trackers
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (rd_pending) begin
      if (rd_valid && (rd_key == item_key) && !found) begin
        found <= 1'b1;
      end
      if (!rd_valid && !have_free) begin
        have_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending && rd_valid && (rd_key == item_key) && !found) begin
      hit_idx <= rd_idx;
      hit_val <= rd_val;
    end
    if (rd_pending && !rd_valid && !have_free) begin
      free_idx <= rd_idx;
    end
  end

  // Update of the table and the result
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = walk_idx;
    wr_data         = {1'b0, item_key, item_val};
    occupancy_next  = occupancy;
    hit_next        = 1'b0;
    read_value_next = '0;
    status_next     = ST_OK;
    if (cmd.sweep_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit) begin
      case (item_op)
        OP_PUT: begin
          if (found) begin
            hit_next = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = hit_idx;
            wr_data  = {1'b1, item_key, item_val};
          end else if (have_free) begin
            wr_en          = 1'b1;
            wr_addr        = free_idx;
            wr_data        = {1'b1, item_key, item_val};
            occupancy_next = occupancy + OCC_W'(1);
          end else begin
            status_next = ST_FULL;
          end
        end
        OP_GET: begin
          if (found) begin
            hit_next        = 1'b1;
            read_value_next = 32'(hit_val);
          end else begin
            status_next = ST_MISS;
          end
        end
        OP_REPLACE: begin
          if (found) begin
            hit_next = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = hit_idx;
            wr_data  = {1'b1, item_key, item_val};
          end else begin
            status_next = ST_MISS;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            hit_next       = 1'b1;
            wr_en          = 1'b1;
            wr_addr        = hit_idx;
            occupancy_next = occupancy - OCC_W'(1);
          end else begin
            status_next = ST_MISS;
          end
        end
        OP_CLEAR: begin
          occupancy_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= hit_next;
      read_value  <= read_value_next;
      status      <= status_next;
      entry_count <= 5'(occupancy_next);
    end
  end

endmodule

>>> design/key_value_table.sv
// Sequence: put, get, replace and remove give their result after a walk of
//   every slot and a drain state; clear sweeps every slot first, and other
//   codes go straight to commit. A new request is taken only once the last
//   result is committed; the walk reads one slot per cycle through the single
//   read port of the slot memory.
// Reset: synchronous; a sweep then invalidates every slot, with in_ready low until it completes.
// ----------------------------------------------------------------------------
// key_value_table
// Bounded associative table of up to ENTRIES unique keys with put, get,
// replace, remove and clear requests, one result per request.
// ----------------------------------------------------------------------------
module key_value_table
  import kvt_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] lookup_key,
  input  logic [31:0] entry_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  // Command and status between the sequencer and the datapath. The sequencer
  // walks every slot once per search request; the datapath keeps the first
  // matching slot and the lowest free slot, then applies the update in one
  // commit cycle that also loads the result register.
  kvt_cmd_t cmd;
  kvt_sts_t sts;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot memory holds {valid, key, value}; clear rewrites each valid bit.
  kvt_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .entry_value (entry_value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .hit         (hit),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

`ifndef ASSERT_OFF
  // A result without a hit never returns data
  a_miss_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == 32'd0)
    else $error("read_value non-zero without a hit");

  // A full report only when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> entry_count == 5'(ENTRIES))
    else $error("table full reported with free slots");

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES > 31) || (entry_count <= 5'(ENTRIES)))
    else $error("entry count beyond table size");

  // No slot access while a request may be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.rd_en || cmd.sweep_wr || cmd.commit))
    else $error("slot access while idle");
`endif

endmodule
